FILE: rtl/vmrp_pkg.sv
// ----------------------------------------------------------------------------
// vmrp_pkg
// Shared types, codes and record tables for the vector media record parser.
// ----------------------------------------------------------------------------
package vmrp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int PT_BITS    = 34;

  localparam logic [3:0] KIND_HEADER = 4'd0;
  localparam logic [3:0] KIND_TITLE  = 4'd1;
  localparam logic [3:0] KIND_QUAD   = 4'd8;
  localparam logic [3:0] KIND_CUBIC  = 4'd9;
  localparam logic [3:0] KIND_STOP   = 4'd10;

  localparam logic [7:0] TAG_SKIP    = 8'd5;
  localparam logic [7:0] TAG_LAST    = 8'd9;
  localparam logic [7:0] TAG_SHIFTED = 8'd4;

  localparam logic [2:0] POS_COUNT = 3'd0;
  localparam logic [2:0] POS_X     = 3'd1;
  localparam logic [2:0] POS_Y     = 3'd2;
  localparam logic [2:0] POS_THICK = 3'd3;
  localparam logic [2:0] POS_COLOR = 3'd4;

  localparam logic [31:0] COLOR_INIT = 32'h0000_00FF;

  typedef struct packed {
    logic               valid;
    logic [3:0]         kind;
    logic [2:0]         pos;
    logic [PT_BITS-1:0] pt;
    logic [31:0]        value;
    logic               done;
    logic               stop;
  } res_t;

  function automatic logic [2:0] field_total(input logic [3:0] kind);
    case (kind)
      4'd0:    field_total = 3'd3;
      4'd1:    field_total = 3'd0;
      4'd2:    field_total = 3'd1;
      4'd3:    field_total = 3'd6;
      4'd4:    field_total = 3'd5;
      4'd5:    field_total = 3'd5;
      4'd6:    field_total = 3'd7;
      4'd7:    field_total = 3'd6;
      4'd8:    field_total = 3'd5;
      4'd9:    field_total = 3'd5;
      default: field_total = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] color_from(input logic [3:0] kind);
    case (kind)
      4'd0:    color_from = 3'd7;
      4'd1:    color_from = 3'd7;
      4'd2:    color_from = 3'd0;
      4'd3:    color_from = 3'd4;
      4'd4:    color_from = 3'd4;
      4'd5:    color_from = 3'd4;
      4'd6:    color_from = 3'd6;
      4'd7:    color_from = 3'd5;
      4'd8:    color_from = 3'd4;
      4'd9:    color_from = 3'd4;
      default: color_from = 3'd7;
    endcase
  endfunction

endpackage

FILE: rtl/vmrp_parse_core.sv
// ----------------------------------------------------------------------------
// vmrp_parse_core
// Parser state and per-byte decode; one byte per step, at most one result.
// ----------------------------------------------------------------------------
module vmrp_parse_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output vmrp_pkg::res_t res
);
  import vmrp_pkg::*;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_TAG  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]            phase, phase_next;
  logic [3:0]            kind, kind_next;
  logic [2:0]            ordinal, ordinal_next;
  logic [7:0]            bytes_left, bytes_left_next;
  logic [VALUE_BITS-1:0] num_acc, num_acc_next;
  logic [31:0]           col_acc, col_acc_next;
  logic [2:0]            col_count, col_count_next;
  logic [PT_BITS-1:0]    points_left, points_left_next;
  logic [PT_BITS-1:0]    point_counter, point_counter_next;

  logic                  is_bez, is_color;
  logic [VALUE_BITS-1:0] num_shift;
  logic [31:0]           col_ins;
  logic [7:0]            bl_dec;
  logic [31:0]           fin_val;
  logic [PT_BITS-1:0]    fin_cnt, fin_pl, fin_pc, pl_dec;
  logic [2:0]            fin_next;
  logic                  fin_last;
  logic [PT_BITS-1:0]    fin_pt;
  res_t                  fin_res;

  assign is_bez    = (kind == KIND_QUAD) || (kind == KIND_CUBIC);
  assign is_color  = (kind <= KIND_CUBIC) && (ordinal >= color_from(kind));
  assign num_shift = {num_acc[VALUE_BITS-9:0], byte_in};
  assign bl_dec    = bytes_left - 8'd1;
  assign pl_dec    = points_left - PT_BITS'(1);

  always_comb begin
    col_ins = col_acc;
    case (col_count)
      3'd0:    col_ins[31:24] = byte_in;
      3'd1:    col_ins[23:16] = byte_in;
      3'd2:    col_ins[15:8]  = byte_in;
      3'd3:    col_ins[7:0]   = byte_in;
      default: col_ins = col_acc;
    endcase
  end

  always_comb begin
    if (phase == PH_LEN) begin
      fin_val = is_color ? COLOR_INIT : 32'd0;
    end else if (is_color) begin
      fin_val = col_ins;
    end else begin
      fin_val = 32'(num_shift);
    end
  end

  always_comb begin
    fin_cnt  = {{(PT_BITS-32){1'b0}}, fin_val};
    fin_pl   = points_left;
    fin_pc   = point_counter;
    fin_next = ordinal + 3'd1;
    fin_pt   = '0;
    if (is_bez) begin
      if (ordinal == POS_X || ordinal == POS_Y) fin_pt = point_counter;
      if (ordinal == POS_COUNT) begin
        fin_pl   = (kind == KIND_QUAD) ? fin_cnt + (fin_cnt << 1) : (fin_cnt << 2);
        fin_pc   = '0;
        fin_next = (fin_pl != '0) ? POS_X : POS_THICK;
      end else if (ordinal == POS_Y) begin
        fin_pc   = point_counter + PT_BITS'(1);
        fin_pl   = pl_dec;
        fin_next = (pl_dec != '0) ? POS_X : POS_THICK;
      end
      fin_last = (ordinal >= POS_COLOR);
    end else begin
      fin_last = ({1'b0, ordinal} + 4'd1) >= {1'b0, field_total(kind)};
    end
    fin_res.valid = 1'b1;
    fin_res.kind  = kind;
    fin_res.pos   = ordinal;
    fin_res.pt    = fin_pt;
    fin_res.value = fin_val;
    fin_res.done  = fin_last;
    fin_res.stop  = 1'b0;
  end

  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    ordinal_next       = ordinal;
    bytes_left_next    = bytes_left;
    num_acc_next       = num_acc;
    col_acc_next       = col_acc;
    col_count_next     = col_count;
    points_left_next   = points_left;
    point_counter_next = point_counter;
    res                = '0;
    if (step) begin
      unique case (phase)
        PH_TAG: begin
          if (byte_in == TAG_SKIP) begin
            phase_next = PH_TAG;
          end else if (byte_in > TAG_LAST) begin
            phase_next = PH_STOP;
            res.valid  = 1'b1;
            res.kind   = KIND_STOP;
            res.stop   = 1'b1;
          end else begin
            kind_next    = (byte_in <= TAG_SHIFTED) ? 4'(byte_in + 8'd1) : byte_in[3:0];
            ordinal_next = '0;
            phase_next   = PH_LEN;
          end
        end
        PH_LEN: begin
          bytes_left_next = byte_in;
          num_acc_next    = '0;
          col_acc_next    = COLOR_INIT;
          col_count_next  = '0;
          if (byte_in != 8'd0) begin
            phase_next = PH_DATA;
          end else if (kind == KIND_TITLE) begin
            phase_next   = PH_TAG;
            ordinal_next = '0;
          end else begin
            res                = fin_res;
            points_left_next   = fin_pl;
            point_counter_next = fin_pc;
            phase_next         = fin_last ? PH_TAG : PH_LEN;
            ordinal_next       = fin_last ? 3'd0 : fin_next;
          end
        end
        PH_DATA: begin
          bytes_left_next = bl_dec;
          if (kind == KIND_TITLE) begin
            res.valid = 1'b1;
            res.kind  = KIND_TITLE;
            res.value = {24'd0, byte_in};
            res.done  = (bytes_left <= 8'd1);
            if (bytes_left <= 8'd1) begin
              phase_next      = PH_TAG;
              ordinal_next    = '0;
              bytes_left_next = '0;
            end
          end else begin
            if (is_color) begin
              if (col_count < 3'd4) begin
                col_acc_next   = col_ins;
                col_count_next = col_count + 3'd1;
              end
            end else begin
              num_acc_next = num_shift;
            end
            if (bl_dec == 8'd0) begin
              res                = fin_res;
              points_left_next   = fin_pl;
              point_counter_next = fin_pc;
              phase_next         = fin_last ? PH_TAG : PH_LEN;
              ordinal_next       = fin_last ? 3'd0 : fin_next;
            end
          end
        end
        PH_STOP: begin
          phase_next = PH_STOP;
        end
        default: begin
          phase_next = PH_STOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      kind          <= KIND_HEADER;
      ordinal       <= '0;
      bytes_left    <= '0;
      num_acc       <= '0;
      col_acc       <= COLOR_INIT;
      col_count     <= '0;
      points_left   <= '0;
      point_counter <= '0;
    end else begin
      phase         <= phase_next;
      kind          <= kind_next;
      ordinal       <= ordinal_next;
      bytes_left    <= bytes_left_next;
      num_acc       <= num_acc_next;
      col_acc       <= col_acc_next;
      col_count     <= col_count_next;
      points_left   <= points_left_next;
      point_counter <= point_counter_next;
    end
  end

endmodule

FILE: rtl/vector_media_record_parser.sv
// ----------------------------------------------------------------------------
// vector_media_record_parser
// Byte-stream parser for vector media headers and tagged records.
// ----------------------------------------------------------------------------
// An accepted byte goes through the input register and the result register.
// Throughput: one byte per cycle unless the master side stalls, set by the single-pass
// decode between the two registers; a byte with no result emits nothing.
// Reset: synchronous rst clears both stage valids and returns the parser to
// expect the header's first length byte.
module vector_media_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // field_position[2:0], point_number[36:3],
                                 // field_value[68:37], zero fill[71:69]
  output logic        m_tlast,   // record_complete
  output logic [4:0]  m_tuser    // record_kind[3:0], parse_stopped[4]
);
  import vmrp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  res_t       res;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  vmrp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {3'b000, res.value, res.pt, res.pos};
      m_tlast <= res.done;
      m_tuser <= {res.stop, res.kind};
    end
  end

  a_stop_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> (m_tuser[3:0] == KIND_STOP) && !m_tlast)
    else $error("stop result with wrong kind or completion");

  a_silent_after_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[4] |=> !m_tvalid)
    else $error("result emitted after stop");

  a_point_bezier_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[36:3] != '0) |->
      (m_tuser[3:0] == KIND_QUAD) || (m_tuser[3:0] == KIND_CUBIC))
    else $error("point number on a non-bezier result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

endmodule

FILE: tb/vector_media_record_parser_tb.sv
// ----------------------------------------------------------------------------
// vector_media_record_parser_tb
// Streams a media file one byte per request into the record parser: a short
// directed opening, a long run of well-formed records with random content,
// then an unknown tag and a few trailing bytes that must be ignored. A model
// of the parser in the bench predicts each field result, and the monitor
// checks every result against the oldest prediction. Both sides idle at
// random, and once the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_media_record_parser_tb;
  import vmrp_pkg::*;

  localparam int STREAM_BYTES = 1950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 500;

  typedef enum logic [1:0] {PH_LEN, PH_DATA, PH_TAG, PH_STOP} parse_phase_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [2:0]         pos;
    logic [PT_BITS-1:0] pt;
    logic [31:0]        value;
    logic               done;
    logic               stop;
  } field_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic [4:0]  m_tuser;

  vector_media_record_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  logic [7:0]    media_bytes[$];
  field_result_t pending_fields[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            results_seen   = 0;
  int            hold_left      = 0;
  bit            hold_started   = 1'b0;

  // parser state as predicted
  const int field_count[10]  = '{3, 0, 1, 6, 5, 5, 7, 6, 5, 5};
  const int colour_start[10] = '{7, 7, 0, 4, 4, 4, 6, 5, 4, 4};

  parse_phase_t       ph         = PH_LEN;
  logic [3:0]         cur_kind   = KIND_HEADER;
  logic [2:0]         cur_ord    = 3'd0;
  logic [7:0]         bytes_left = 8'd0;
  logic [31:0]        num_acc    = 32'd0;
  logic [31:0]        col_acc    = COLOR_INIT;
  logic [PT_BITS-1:0] pts_left   = '0;
  logic [PT_BITS-1:0] pt_idx     = '0;
  int                 col_bytes  = 0;
  bit                 halted     = 1'b0;

  function automatic logic colour_field();
    return (cur_kind <= 4'd9) && (cur_ord >= colour_start[cur_kind]);
  endfunction

  task automatic close_field(input logic [31:0] v);
    field_result_t r;
    logic          last;
    logic [3:0]    nxt;
    r       = '0;
    r.kind  = cur_kind;
    r.pos   = cur_ord;
    r.value = v;
    nxt     = {1'b0, cur_ord} + 4'd1;
    if (cur_kind == KIND_QUAD || cur_kind == KIND_CUBIC) begin
      if (cur_ord == POS_X || cur_ord == POS_Y) r.pt = pt_idx;
      if (cur_ord == POS_COUNT) begin
        pts_left = {2'b00, v} * ((cur_kind == KIND_QUAD) ? 34'd3 : 34'd4);
        pt_idx   = '0;
        nxt      = (pts_left != 0) ? {1'b0, POS_X} : {1'b0, POS_THICK};
      end else if (cur_ord == POS_Y) begin
        pt_idx   = pt_idx + 1'b1;
        pts_left = pts_left - 1'b1;
        nxt      = (pts_left != 0) ? {1'b0, POS_X} : {1'b0, POS_THICK};
      end
      last = (cur_ord >= POS_COLOR);
    end else begin
      last = (nxt >= field_count[cur_kind]);
    end
    r.done = last;
    pending_fields.push_back(r);
    if (last) begin
      ph      = PH_TAG;
      cur_ord = 3'd0;
    end else begin
      ph      = PH_LEN;
      cur_ord = nxt[2:0];
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    field_result_t r;
    logic          fin;
    r = '0;
    if (!halted) begin
      case (ph)
        PH_TAG: begin
          if (b == TAG_SKIP) begin
          end else if (b > TAG_LAST) begin
            halted = 1'b1;
            ph     = PH_STOP;
            r.kind = KIND_STOP;
            r.stop = 1'b1;
            pending_fields.push_back(r);
          end else begin
            cur_kind = (b <= TAG_SHIFTED) ? b[3:0] + 4'd1 : b[3:0];
            cur_ord  = 3'd0;
            ph       = PH_LEN;
          end
        end
        PH_LEN: begin
          bytes_left = b;
          num_acc    = 32'd0;
          col_acc    = COLOR_INIT;
          col_bytes  = 0;
          if (b != 8'd0) begin
            ph = PH_DATA;
          end else if (cur_kind == KIND_TITLE) begin
            ph      = PH_TAG;
            cur_ord = 3'd0;
          end else begin
            close_field(colour_field() ? col_acc : 32'd0);
          end
        end
        PH_DATA: begin
          if (cur_kind == KIND_TITLE) begin
            fin     = (bytes_left <= 8'd1);
            r.kind  = KIND_TITLE;
            r.value = {24'd0, b};
            r.done  = fin;
            pending_fields.push_back(r);
            bytes_left = bytes_left - 8'd1;
            if (fin) begin
              ph         = PH_TAG;
              cur_ord    = 3'd0;
              bytes_left = 8'd0;
            end
          end else begin
            if (colour_field()) begin
              if (col_bytes < 4) begin
                col_acc[31 - 8 * col_bytes -: 8] = b;
                col_bytes++;
              end
            end else begin
              num_acc = {num_acc[23:0], b};
            end
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) close_field(colour_field() ? col_acc : num_acc);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  // stream construction
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 999);
    if (r < 80) return 0;
    if (r < 750) return $urandom_range(1, 4);
    if (r < 950) return $urandom_range(5, 8);
    if (r < 998) return $urandom_range(9, 40);
    return 255;
  endfunction

  task automatic push_field(input int len);
    media_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++) media_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_bezier(input int mult);
    int c;
    int len;
    c   = $urandom_range(0, 3);
    len = (c == 0 && $urandom_range(0, 1)) ? 0 : $urandom_range(1, 8);
    media_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i < len - 4) media_bytes.push_back(8'($urandom_range(0, 255)));
      else media_bytes.push_back((i == len - 1) ? 8'(c) : 8'd0);
    end
    for (int j = 0; j < c * mult; j++) begin
      push_field(rand_len());
      push_field(rand_len());
    end
    push_field(rand_len());
    push_field(rand_len());
  endtask

  task automatic push_record(input int tag);
    int n;
    media_bytes.push_back(8'(tag));
    case (tag)
      0: begin
        n = ($urandom_range(0, 99) == 0) ? 255 : $urandom_range(0, 12);
        push_field(n);
      end
      1: push_field(rand_len());
      2: for (int i = 0; i < 6; i++) push_field(rand_len());
      3, 4: for (int i = 0; i < 5; i++) push_field(rand_len());
      6: for (int i = 0; i < 7; i++) push_field(rand_len());
      7: for (int i = 0; i < 6; i++) push_field(rand_len());
      8: push_bezier(3);
      9: push_bezier(4);
      default: begin
      end
    endcase
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int send_gap  = 0;
  int sent_bytes = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata);
        sent_bytes++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (media_bytes.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= media_bytes.pop_front();
          send_gap = pick_gap(((sent_bytes / 128) % 4) == 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the stream is under way
  always @(posedge clk) begin
    if (!hold_started && results_seen >= HOLD_AFTER) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  int            ready_gap = 0;
  field_result_t got;
  field_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind  = m_tuser[3:0];
        got.stop  = m_tuser[4];
        got.pos   = m_tdata[2:0];
        got.pt    = m_tdata[36:3];
        got.value = m_tdata[68:37];
        got.done  = m_tlast;
        results_seen <= results_seen + 1;
        if (pending_fields.size() == 0) begin
          $display("%0t: unexpected result kind %0d pos %0d pt %0d value %h done %b stop %b",
                   $time, got.kind, got.pos, got.pt, got.value, got.done, got.stop);
          mismatch_count++;
        end else begin
          want = pending_fields.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind %0d pos %0d pt %0d value %h done %b stop %b",
                     $time, want.kind, want.pos, want.pt, want.value, want.done, want.stop);
            $display("%0t:          actual   kind %0d pos %0d pt %0d value %h done %b stop %b",
                     $time, got.kind, got.pos, got.pt, got.value, got.done, got.stop);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        ready_gap = pick_gap(((results_seen / 100) % 4) == 1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_fields.size());
      $display("vector_media_record_parser_tb failed");
      $finish;
    end
  end

  initial begin
    // directed opening: header extremes, empty title, skipped tag, colours, empty bezier
    media_bytes = '{8'd0, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 8'h00,
                    8'd0, 8'd0,
                    8'd5,
                    8'd1, 8'd0,
                    8'd1, 8'd5, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55,
                    8'd8, 8'd0, 8'd1, 8'h80, 8'd2, 8'hAB, 8'hCD};
    while (media_bytes.size() < STREAM_BYTES) push_record($urandom_range(0, 9));
    media_bytes.push_back(8'($urandom_range(10, 255)));
    for (int i = 0; i < 8; i++) media_bytes.push_back(8'($urandom_range(0, 255)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (media_bytes.size() > 0 || s_tvalid || pending_fields.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_fields.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_fields.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("vector_media_record_parser_tb passed");
    end else begin
      $display("vector_media_record_parser_tb failed");
    end
    $finish;
  end

endmodule
